### hw/rtl/pgs_pkg.sv
// Package with the shared types and constants of the prime gap search unit.
`timescale 1ns / 1ps
package pgs_pkg;

	localparam logic [31:0] LIMIT_AT_RESET = 32'd1000000000;
	localparam int GAP_BITS = 10;
	localparam logic [GAP_BITS-1:0] GAP_CEILING = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WIDTH,
		ST_BOUNDS,
		ST_NEXT,
		ST_SQUARE,
		ST_CHECK,
		ST_DIVIDE,
		ST_RECORD,
		ST_DONE
	} pgs_state_t;

	typedef struct packed {
		logic start_width;
		logic set_bounds;
		logic next_candidate;
		logic square;
		logic start_divide;
		logic next_divisor;
		logic record_prime;
		logic load_result;
	} pgs_cmd_t;

	typedef struct packed {
		logic width_done;
		logic walk_done;
		logic square_above;
		logic below_two;
		logic divide_done;
		logic divides;
	} pgs_status_t;

endpackage

### hw/rtl/pgs_divider.sv
// Restoring divider that produces one quotient bit a cycle.
`timescale 1ns / 1ps
module pgs_divider import pgs_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);
	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] quot_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] div_q;
	logic [CW-1:0]    count_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   trial;

	assign trial = {rem_q, quot_q[WIDTH-1]} - {1'b0, div_q};

	// Done is raised in the cycle after the last step, when quotient and
	// remainder are final.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (count_q == CW'(1));
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= CW'(WIDTH);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			if (!trial[WIDTH]) begin
				rem_q  <= trial[WIDTH-1:0];
				quot_q <= {quot_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[WIDTH-2:0], quot_q[WIDTH-1]};
				quot_q <= {quot_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;
endmodule

### hw/rtl/pgs_datapath.sv
// Datapath: slice bounds, candidate walk, trial division and gap tracking.
`timescale 1ns / 1ps
module pgs_datapath import pgs_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pgs_cmd_t         cmd,
	output pgs_status_t      status,
	input  logic [31:0]      limit,
	input  logic [5:0]       rank,
	input  logic [6:0]       count,
	output logic [31:0]      res_first,
	output logic [31:0]      res_last,
	output logic [31:0]      res_gap_low,
	output logic [31:0]      res_gap_high,
	output logic [GAP_BITS-1:0] res_gap,
	output logic             res_none
);
	logic [WIDTH-1:0] limit_w;
	logic [WIDTH-1:0] width_q;
	logic [WIDTH-1:0] lo_q, hi_q;
	logic [WIDTH-1:0] cand_q, div_q;
	logic [WIDTH-1:0] first_q, prev_q, best_low_q, best_high_q, best_raw_q;
	logic [1:0]       found_q;
	logic [2*WIDTH-1:0] sq_s1;
	logic [WIDTH-1:0] dvd, dvs, quo, rem;
	logic             dv_start, dv_done;
	logic [WIDTH+6:0] lo_full, hi_full;
	logic [WIDTH-1:0] gap;

	if (WIDTH >= 32) begin : g_wide
		assign limit_w = WIDTH'(limit);
	end else begin : g_narrow
		assign limit_w = limit[WIDTH-1:0];
	end

	assign dv_start = cmd.start_width || cmd.start_divide;
	assign dvd = cmd.start_width ? limit_w : cand_q;
	assign dvs = cmd.start_width ? WIDTH'(count) : div_q;

	pgs_divider #(.WIDTH(WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dvd), .divisor(dvs),
		.done(dv_done), .quotient(quo), .remainder(rem)
	);

	assign lo_full = (WIDTH+7)'(width_q) * (WIDTH+7)'(rank - 6'd1);
	assign hi_full = (WIDTH+7)'(width_q) * (WIDTH+7)'(rank);
	assign gap = cand_q - prev_q;

	always_ff @(posedge clk) begin
		if (cmd.start_width) begin
			found_q    <= '0;
			best_raw_q <= '0;
			first_q    <= '0;
			prev_q     <= '0;
			best_low_q <= '0;
			best_high_q<= '0;
			width_q    <= '0;
		end
		if (cmd.set_bounds) begin
			lo_q   <= (lo_full > (WIDTH+7)'(limit_w)) ? limit_w : lo_full[WIDTH-1:0];
			hi_q   <= (hi_full > (WIDTH+7)'(limit_w)) ? limit_w : hi_full[WIDTH-1:0];
			cand_q <= (lo_full > (WIDTH+7)'(limit_w)) ? limit_w : lo_full[WIDTH-1:0];
		end
		if (status.width_done && !cmd.set_bounds && !cmd.start_width) begin
			width_q <= quo;
		end
		if (cmd.next_candidate) begin
			cand_q <= cand_q + 1'b1;
			div_q  <= WIDTH'(2);
		end
		if (cmd.square) begin
			sq_s1 <= div_q * div_q;
		end
		if (cmd.next_divisor) begin
			div_q <= div_q + 1'b1;
		end
		if (cmd.record_prime) begin
			if (found_q == 2'd0) begin
				first_q <= cand_q;
			end else if (gap > best_raw_q) begin
				best_raw_q  <= gap;
				best_low_q  <= prev_q;
				best_high_q <= cand_q;
			end
			prev_q <= cand_q;
			if (found_q != 2'd2) begin
				found_q <= found_q + 1'b1;
			end
		end
		if (cmd.load_result) begin
			res_first    <= 32'(first_q);
			res_last     <= 32'(prev_q);
			res_none     <= (found_q != 2'd2);
			res_gap_low  <= (found_q == 2'd2) ? 32'(best_low_q) : '0;
			res_gap_high <= (found_q == 2'd2) ? 32'(best_high_q) : '0;
			res_gap      <= (found_q != 2'd2) ? '0 :
				(best_raw_q > WIDTH'(GAP_CEILING)) ? GAP_CEILING : best_raw_q[GAP_BITS-1:0];
		end
	end

	// Width done is the divider finishing during the width phase; the controller qualifies it.
	assign status.width_done   = dv_done;
	assign status.divide_done  = dv_done;
	assign status.divides      = (rem == '0);
	assign status.walk_done    = (cand_q + 1'b1 >= hi_q) || (cand_q + 1'b1 == '0);
	assign status.square_above = sq_s1 > (2*WIDTH)'(cand_q);
	assign status.below_two    = cand_q < WIDTH'(2);
endmodule

### hw/rtl/pgs_controller.sv
// Controller state machine sequencing one slice search.
`timescale 1ns / 1ps
module pgs_controller import pgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_stall,
	input  logic        empty_job,
	input  logic        out_full,
	output logic        out_load,
	input  pgs_status_t status,
	output pgs_cmd_t    cmd
);
	pgs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (job_valid) state_d = ST_WIDTH;
			ST_WIDTH:  if (empty_job || status.width_done) state_d = ST_BOUNDS;
			ST_BOUNDS: state_d = ST_NEXT;
			ST_NEXT:   state_d = status.walk_done ? ST_DONE : ST_SQUARE;
			ST_SQUARE: state_d = ST_CHECK;
			ST_CHECK: begin
				priority if (status.below_two) state_d = ST_NEXT;
				else if (status.square_above) state_d = ST_RECORD;
				else state_d = ST_DIVIDE;
			end
			ST_DIVIDE: if (status.divide_done) state_d = status.divides ? ST_NEXT : ST_SQUARE;
			ST_RECORD: state_d = ST_NEXT;
			ST_DONE:   if (!out_full) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		job_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				job_stall = 1'b0;
				cmd.start_width = job_valid;
			end
			ST_WIDTH:  cmd.set_bounds = empty_job;
			ST_BOUNDS: cmd.set_bounds = 1'b1;
			ST_NEXT:   cmd.next_candidate = !status.walk_done;
			ST_SQUARE: cmd.square = 1'b1;
			ST_CHECK:  cmd.start_divide = !status.below_two && !status.square_above;
			ST_DIVIDE: cmd.next_divisor = status.divide_done && !status.divides;
			ST_RECORD: cmd.record_prime = 1'b1;
			ST_DONE: begin
				cmd.load_result = !out_full;
				out_load = !out_full;
			end
			default: ;
		endcase
	end
endmodule

### hw/rtl/prime_gap_search_unit.sv
// Top level of the prime gap search unit.
`timescale 1ns / 1ps
// Usage: a job transfer on the input channel (valid, stall) carries slice_rank and
// slice_count. The unit splits [0, search_limit) into slice_count slices, walks
// every number strictly inside the chosen slice and decides primality by trial
// division with a shared bit-serial divider, divisors i while i*i <= n.
// One result transfer follows each job on the output channel (valid, stall):
// first and last prime, the widest gap between neighbouring primes with its
// bounding primes, and a flag for fewer than two primes.
// The slice width comes first from one division; then each candidate n is
// tested by trial divisors up to sqrt(n), each a full division in the one
// divider, which takes one quotient bit a cycle. One job is in flight at a
// time; the next job is taken once the result sits in the output register, so
// a stalled receiver holds the result steady and the next job may already run.
// The user must write search_limit over its own channel only while idle; the
// block itself does not enforce it. Reset sets search_limit to 1000000000 and
// empties the output register.
module prime_gap_search_unit import pgs_pkg::*; #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  slice_rank,
	input  logic [6:0]  slice_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] first_prime,
	output logic [31:0] last_prime,
	output logic [31:0] gap_low_prime,
	output logic [31:0] gap_high_prime,
	output logic [GAP_BITS-1:0] gap_size,
	output logic        none_found
);
	logic [31:0] limit_q;
	logic [5:0]  rank_q;
	logic [6:0]  count_q;
	logic        out_valid_q;
	logic        out_load;
	logic        empty_job;
	pgs_cmd_t    cmd;
	pgs_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_AT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Job fields are captured on the transfer and held for the whole walk.
	always_ff @(posedge clk) begin
		if (cmd.start_width) begin
			rank_q  <= slice_rank;
			count_q <= slice_count;
		end
	end

	// An empty rank or count yields an empty slice; the bounds are set while the width is still zero.
	assign empty_job = (rank_q == '0) || (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end
	assign out_valid = out_valid_q;

	pgs_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .job_valid(in_valid), .job_stall(in_stall),
		.empty_job(empty_job), .out_full(out_valid_q && out_stall), .out_load(out_load),
		.status(status), .cmd(cmd)
	);

	// The width division starts on the job transfer itself, so the divisor is
	// taken straight from the input port rather than from the captured copy.
	pgs_datapath #(.WIDTH(NUMBER_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.limit(limit_q), .rank(rank_q), .count(slice_count),
		.res_first(first_prime), .res_last(last_prime),
		.res_gap_low(gap_low_prime), .res_gap_high(gap_high_prime),
		.res_gap(gap_size), .res_none(none_found)
	);

	// A result is only loaded when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n) out_load |-> !(out_valid && out_stall))
		else $error("result loaded over a stalled result");
	// A job transfer only happens while no other job is in flight.
	assert property (@(posedge clk) disable iff (!arst_n) (in_valid && !in_stall) |=> in_stall)
		else $error("second job taken while busy");
	// A new result appears the cycle after a load.
	assert property (@(posedge clk) disable iff (!arst_n) out_load |=> out_valid)
		else $error("result not presented after load");
endmodule
